>>> design/cth_pkg.sv
// Shared types, codes and the codon walk table for the codon translation histogram.
// Used by every module of the block; depends on nothing.
package cth_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int FIFO_DEPTH_DEF  = 4;
	localparam int NUM_ACIDS       = 20;
	localparam int NUM_STATES      = 24;
	localparam int OUT_WIDTH       = 32;

	// Input actions.
	localparam logic [1:0] ACT_FEED  = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// Operations handed from the front to the back.
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_COUNT = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Reader states with a fixed meaning.
	localparam logic [4:0] ST_SEARCH   = 5'd0;
	localparam logic [4:0] ST_BOUNDARY = 5'd3;

	// Table entries: below 24 a next state, 31 a stop, 32 plus i amino acid i.
	localparam logic [5:0] ENT_STOP = 6'd31;
	localparam logic [5:0] AA_A = 6'd32;
	localparam logic [5:0] AA_C = 6'd33;
	localparam logic [5:0] AA_D = 6'd34;
	localparam logic [5:0] AA_E = 6'd35;
	localparam logic [5:0] AA_F = 6'd36;
	localparam logic [5:0] AA_G = 6'd37;
	localparam logic [5:0] AA_H = 6'd38;
	localparam logic [5:0] AA_I = 6'd39;
	localparam logic [5:0] AA_K = 6'd40;
	localparam logic [5:0] AA_L = 6'd41;
	localparam logic [5:0] AA_M = 6'd42;
	localparam logic [5:0] AA_N = 6'd43;
	localparam logic [5:0] AA_P = 6'd44;
	localparam logic [5:0] AA_Q = 6'd45;
	localparam logic [5:0] AA_R = 6'd46;
	localparam logic [5:0] AA_S = 6'd47;
	localparam logic [5:0] AA_T = 6'd48;
	localparam logic [5:0] AA_V = 6'd49;
	localparam logic [5:0] AA_W = 6'd50;
	localparam logic [5:0] AA_Y = 6'd51;

	// Columns are T, C, A, G.
	localparam logic [5:0] CODON_TABLE [NUM_STATES][4] = '{
		'{6'd0,  6'd0,  6'd1,     6'd0},
		'{6'd2,  6'd0,  6'd1,     6'd0},
		'{6'd0,  6'd0,  6'd1,     AA_M},
		'{6'd4,  6'd9,  6'd14,    6'd19},
		'{6'd5,  6'd6,  6'd7,     6'd8},
		'{AA_F,  AA_F,  AA_L,     AA_L},
		'{AA_S,  AA_S,  AA_S,     AA_S},
		'{AA_Y,  AA_Y,  ENT_STOP, ENT_STOP},
		'{AA_C,  AA_C,  ENT_STOP, AA_W},
		'{6'd10, 6'd11, 6'd12,    6'd13},
		'{AA_L,  AA_L,  AA_L,     AA_L},
		'{AA_P,  AA_P,  AA_P,     AA_P},
		'{AA_H,  AA_H,  AA_Q,     AA_Q},
		'{AA_R,  AA_R,  AA_R,     AA_R},
		'{6'd15, 6'd16, 6'd17,    6'd18},
		'{AA_I,  AA_I,  AA_I,     AA_M},
		'{AA_T,  AA_T,  AA_T,     AA_T},
		'{AA_N,  AA_N,  AA_K,     AA_K},
		'{AA_S,  AA_S,  AA_R,     AA_R},
		'{6'd20, 6'd21, 6'd22,    6'd23},
		'{AA_V,  AA_V,  AA_V,     AA_V},
		'{AA_A,  AA_A,  AA_A,     AA_A},
		'{AA_D,  AA_D,  AA_E,     AA_E},
		'{AA_G,  AA_G,  AA_G,     AA_G}
	};

	// One classified beat travelling from the front to the back.
	typedef struct packed {
		logic [1:0] op;
		logic [4:0] acid_code;
		logic       stop_seen;
		logic       in_protein;
		logic [4:0] acid_select;
	} cmd_t;

endpackage

>>> design/codon_translation_histogram.sv
// Codon translation histogram, top level: front end, command queue, counter back end.
// A beat is written to the queue when accepted; the back end then registers its result.
// Throughput: one beat per cycle while results are popped; the front walks one codon table
// step per beat, the back end one counter increment per beat, the queue decoupling the two.
// Reset is asynchronous and clears reader state, all counters and the queue at once.
module codon_translation_histogram #(
	parameter int COUNT_WIDTH = cth_pkg::COUNT_WIDTH_DEF,
	parameter int FIFO_DEPTH  = cth_pkg::FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [7:0]  nucleotide,
	input  logic [4:0]  acid_select,
	output logic        empty,
	input  logic        pop,
	output logic        acid_valid,
	output logic [4:0]  acid_code,
	output logic        stop_seen,
	output logic        in_protein,
	output logic [31:0] selected_count,
	output logic [31:0] total_count
);
	import cth_pkg::*;

	cmd_t front_cmd;
	cmd_t queue_cmd;
	logic accept;
	logic queue_empty;
	logic queue_take;

	assign accept = push && !full;

	cth_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.action      (action),
		.nucleotide  (nucleotide),
		.acid_select (acid_select),
		.cmd         (front_cmd)
	);

	cth_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (front_cmd),
		.full    (full),
		.rd_en   (queue_take),
		.rd_data (queue_cmd),
		.empty   (queue_empty)
	);

	cth_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (queue_cmd),
		.cmd_avail      (!queue_empty),
		.cmd_take       (queue_take),
		.pop            (pop),
		.empty          (empty),
		.acid_valid     (acid_valid),
		.acid_code      (acid_code),
		.stop_seen      (stop_seen),
		.in_protein     (in_protein),
		.selected_count (selected_count),
		.total_count    (total_count)
	);

endmodule

>>> design/cth_front.sv
// Front end: decodes each accepted beat and walks the codon reader state.
// Depends on cth_pkg for the codon table, action codes and cmd_t.
module cth_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [1:0]    action,
	input  logic [7:0]    nucleotide,
	input  logic [4:0]    acid_select,
	output cth_pkg::cmd_t cmd
);
	import cth_pkg::*;

	logic [4:0] reader_state_q;
	logic [4:0] state_d;
	logic [4:0] row;
	logic [1:0] col;
	logic       base_ok;
	logic [5:0] entry;

	always_comb begin
		base_ok = 1'b1;
		unique case (nucleotide)
			8'h54: col = 2'd0;
			8'h43: col = 2'd1;
			8'h41: col = 2'd2;
			8'h47: col = 2'd3;
			default: begin
				col = 2'd0;
				base_ok = 1'b0;
			end
		endcase
	end

	assign row   = (reader_state_q < 5'(NUM_STATES)) ? reader_state_q : ST_SEARCH;
	assign entry = CODON_TABLE[row][col];

	always_comb begin
		state_d         = reader_state_q;
		cmd.op          = OP_NONE;
		cmd.acid_code   = 5'd0;
		cmd.stop_seen   = 1'b0;
		cmd.acid_select = acid_select;
		unique case (action)
			ACT_FEED: begin
				if (base_ok) begin
					if (entry == ENT_STOP) begin
						cmd.stop_seen = 1'b1;
						state_d = ST_SEARCH;
					end else if (entry[5]) begin
						cmd.op = OP_COUNT;
						cmd.acid_code = entry[4:0];
						state_d = ST_BOUNDARY;
					end else begin
						state_d = entry[4:0];
					end
				end
			end
			ACT_CLEAR: begin
				cmd.op = OP_CLEAR;
				state_d = ST_SEARCH;
			end
			default: begin
			end
		endcase
		cmd.in_protein = (state_d >= ST_BOUNDARY) && (state_d < 5'(NUM_STATES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reader_state_q <= ST_SEARCH;
		end else if (accept) begin
			reader_state_q <= state_d;
		end
	end

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		reader_state_q < 5'(NUM_STATES))
		else $error("reader state left the table");

	a_clear_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == ACT_CLEAR |=> reader_state_q == ST_SEARCH)
		else $error("clear did not restart the start search");

	a_count_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.op == OP_COUNT |=> reader_state_q == ST_BOUNDARY)
		else $error("counted codon did not return to a codon boundary");

endmodule

>>> design/cth_fifo.sv
// Short command queue between the front end and the counter back end.
// Depends on cth_pkg for cmd_t.
module cth_fifo #(
	parameter int DEPTH = cth_pkg::FIFO_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  cth_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output cth_pkg::cmd_t rd_data,
	output logic          empty
);
	import cth_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count overran its depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree while empty");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue fill count missed a write");

endmodule

>>> design/cth_back.sv
// Back end: saturating amino acid counters, running total and the result register.
// Depends on cth_pkg for cmd_t, operation codes and sizes.
module cth_back #(
	parameter int COUNT_WIDTH = cth_pkg::COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cth_pkg::cmd_t cmd,
	input  logic          cmd_avail,
	output logic          cmd_take,
	input  logic          pop,
	output logic          empty,
	output logic          acid_valid,
	output logic [4:0]    acid_code,
	output logic          stop_seen,
	output logic          in_protein,
	output logic [31:0]   selected_count,
	output logic [31:0]   total_count
);
	import cth_pkg::*;

	logic [COUNT_WIDTH-1:0] counts_q [NUM_ACIDS];
	logic [COUNT_WIDTH-1:0] counts_d [NUM_ACIDS];
	logic [COUNT_WIDTH-1:0] total_q;
	logic [COUNT_WIDTH-1:0] total_d;
	logic [COUNT_WIDTH-1:0] sel_d;
	logic                   out_valid_q;

	// The result register frees up in the same cycle it is popped.
	assign cmd_take = cmd_avail && (!out_valid_q || pop);
	assign empty    = !out_valid_q;

	always_comb begin
		for (int i = 0; i < NUM_ACIDS; i++) begin
			if (cmd.op == OP_CLEAR) begin
				counts_d[i] = '0;
			end else if (cmd.op == OP_COUNT && cmd.acid_code == 5'(i)
				&& counts_q[i] != '1) begin
				counts_d[i] = counts_q[i] + COUNT_WIDTH'(1);
			end else begin
				counts_d[i] = counts_q[i];
			end
		end
		if (cmd.op == OP_CLEAR) begin
			total_d = '0;
		end else if (cmd.op == OP_COUNT && total_q != '1) begin
			total_d = total_q + COUNT_WIDTH'(1);
		end else begin
			total_d = total_q;
		end
		sel_d = (cmd.acid_select < 5'(NUM_ACIDS)) ? counts_d[cmd.acid_select] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ACIDS; i++) begin
				counts_q[i] <= '0;
			end
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				for (int i = 0; i < NUM_ACIDS; i++) begin
					counts_q[i] <= counts_d[i];
				end
				total_q     <= total_d;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			acid_valid     <= (cmd.op == OP_COUNT);
			acid_code      <= cmd.acid_code;
			stop_seen      <= cmd.stop_seen;
			in_protein     <= cmd.in_protein;
			selected_count <= OUT_WIDTH'(sel_d);
			total_count    <= OUT_WIDTH'(total_d);
		end
	end

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take && cmd.op == OP_COUNT |=> total_q != '0)
		else $error("total is zero after a counted amino acid");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take && cmd.op == OP_CLEAR |=> total_q == '0 && counts_q[0] == '0)
		else $error("clear left counters standing");

	a_acid_not_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(acid_valid && stop_seen))
		else $error("result marks both an amino acid and a stop");

	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take && cmd.op != OP_CLEAR |=> total_q >= $past(total_q))
		else $error("running total went backwards without a clear");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for codon_translation_histogram: drives beats and pops results at random rates,
// and checks every result against a scoreboard that translates codons by the genetic code.
// Depends on cth_pkg and the design sources; reads no files.
module tb_top;
	import cth_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 1900;
	localparam int CALM_AFTER  = 1650;
	localparam int CODON_STOP  = 31;

	// The action code that the block treats as a plain read.
	localparam logic [1:0] ACT_SPARE = 2'd3;

	localparam logic [1:0] BASE_T = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_A = 2'd2;
	localparam logic [1:0] BASE_G = 2'd3;

	localparam logic [7:0] CHAR_T = 8'h54;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_G = 8'h47;

	localparam int ACID_A = 0;
	localparam int ACID_C = 1;
	localparam int ACID_D = 2;
	localparam int ACID_E = 3;
	localparam int ACID_F = 4;
	localparam int ACID_G = 5;
	localparam int ACID_H = 6;
	localparam int ACID_I = 7;
	localparam int ACID_K = 8;
	localparam int ACID_L = 9;
	localparam int ACID_M = 10;
	localparam int ACID_N = 11;
	localparam int ACID_P = 12;
	localparam int ACID_Q = 13;
	localparam int ACID_R = 14;
	localparam int ACID_S = 15;
	localparam int ACID_T = 16;
	localparam int ACID_V = 17;
	localparam int ACID_W = 18;
	localparam int ACID_Y = 19;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  action;
	logic [7:0]  nucleotide;
	logic [4:0]  acid_select;
	logic        empty;
	logic        pop;
	logic        acid_valid;
	logic [4:0]  acid_code;
	logic        stop_seen;
	logic        in_protein;
	logic [31:0] selected_count;
	logic [31:0] total_count;

	typedef struct {
		logic        acid_valid;
		logic [4:0]  acid_code;
		logic        stop_seen;
		logic        in_protein;
		logic [31:0] selected_count;
		logic [31:0] total_count;
	} histo_result_t;

	function automatic int base_index(logic [7:0] nuc);
		case (nuc)
			CHAR_T: return BASE_T;
			CHAR_C: return BASE_C;
			CHAR_A: return BASE_A;
			CHAR_G: return BASE_G;
			default: return -1;
		endcase
	endfunction

	function automatic logic [7:0] base_char(logic [1:0] b);
		case (b)
			BASE_T: return CHAR_T;
			BASE_C: return CHAR_C;
			BASE_A: return CHAR_A;
			default: return CHAR_G;
		endcase
	endfunction

	// Standard genetic code. Bit 1 of a base is set for A and G, so the
	// third-base splits T/C against A/G fall out of that bit alone.
	function automatic int translate_codon(logic [1:0] b1, logic [1:0] b2, logic [1:0] b3);
		case ({b1, b2})
			{BASE_T, BASE_T}: return b3[1] ? ACID_L : ACID_F;
			{BASE_T, BASE_C}: return ACID_S;
			{BASE_T, BASE_A}: return b3[1] ? CODON_STOP : ACID_Y;
			{BASE_T, BASE_G}: begin
				if (!b3[1])
					return ACID_C;
				return (b3 == BASE_A) ? CODON_STOP : ACID_W;
			end
			{BASE_C, BASE_T}: return ACID_L;
			{BASE_C, BASE_C}: return ACID_P;
			{BASE_C, BASE_A}: return b3[1] ? ACID_Q : ACID_H;
			{BASE_C, BASE_G}: return ACID_R;
			{BASE_A, BASE_T}: return (b3 == BASE_G) ? ACID_M : ACID_I;
			{BASE_A, BASE_C}: return ACID_T;
			{BASE_A, BASE_A}: return b3[1] ? ACID_K : ACID_N;
			{BASE_A, BASE_G}: return b3[1] ? ACID_R : ACID_S;
			{BASE_G, BASE_T}: return ACID_V;
			{BASE_G, BASE_C}: return ACID_A;
			{BASE_G, BASE_A}: return b3[1] ? ACID_E : ACID_D;
			default: return ACID_G;
		endcase
	endfunction

	class histogram_scoreboard;
		bit            protein;
		int            start_stage;
		int            bases_held;
		logic [1:0]    first_base;
		logic [1:0]    second_base;
		logic [31:0]   acid_counts [NUM_ACIDS];
		logic [31:0]   grand_total;
		histo_result_t expected_q [$];
		int            errors;

		function new();
			clear_state();
			errors = 0;
		endfunction

		function void clear_state();
			protein = 1'b0;
			start_stage = 0;
			bases_held = 0;
			first_base = BASE_T;
			second_base = BASE_T;
			foreach (acid_counts[i])
				acid_counts[i] = '0;
			grand_total = '0;
		endfunction

		function void count_acid(int idx);
			if (acid_counts[idx] != '1)
				acid_counts[idx] = acid_counts[idx] + 32'd1;
			if (grand_total != '1)
				grand_total = grand_total + 32'd1;
		endfunction

		// Advances the predicted reader by one accepted beat and queues its result.
		function void note_beat(logic [1:0] act, logic [7:0] nuc, logic [4:0] sel);
			histo_result_t r;
			int col;
			int acid;
			r.acid_valid = 1'b0;
			r.acid_code = '0;
			r.stop_seen = 1'b0;
			col = base_index(nuc);
			if (act == ACT_CLEAR) begin
				clear_state();
			end else if (act == ACT_FEED && col >= 0) begin
				if (!protein) begin
					// Searching for ATG; a fresh A always restarts the match.
					if (start_stage == 2 && col == BASE_G) begin
						count_acid(ACID_M);
						r.acid_valid = 1'b1;
						r.acid_code = 5'(ACID_M);
						protein = 1'b1;
						bases_held = 0;
						start_stage = 0;
					end else if (start_stage == 1 && col == BASE_T) begin
						start_stage = 2;
					end else begin
						start_stage = (col == BASE_A) ? 1 : 0;
					end
				end else if (bases_held == 0) begin
					first_base = 2'(col);
					bases_held = 1;
				end else if (bases_held == 1) begin
					second_base = 2'(col);
					bases_held = 2;
				end else begin
					acid = translate_codon(first_base, second_base, 2'(col));
					bases_held = 0;
					if (acid == CODON_STOP) begin
						r.stop_seen = 1'b1;
						protein = 1'b0;
						start_stage = 0;
					end else begin
						count_acid(acid);
						r.acid_valid = 1'b1;
						r.acid_code = 5'(acid);
					end
				end
			end
			r.in_protein = protein;
			r.selected_count = (sel < NUM_ACIDS) ? acid_counts[sel] : '0;
			r.total_count = grand_total;
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] expv, logic [31:0] actv);
			if (actv !== expv) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, name, expv, actv);
				errors++;
			end
		endfunction

		function void check_beat(logic v, logic [4:0] code, logic stop, logic inp,
				logic [31:0] sel_cnt, logic [31:0] tot);
			histo_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: result beat with no input outstanding", $time);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			compare_field("acid_valid", 32'(e.acid_valid), 32'(v));
			compare_field("acid_code", 32'(e.acid_code), 32'(code));
			compare_field("stop_seen", 32'(e.stop_seen), 32'(stop));
			compare_field("in_protein", 32'(e.in_protein), 32'(inp));
			compare_field("selected_count", e.selected_count, sel_cnt);
			compare_field("total_count", e.total_count, tot);
		endfunction
	endclass

	histogram_scoreboard sb = new();
	int items_sent;
	bit calm;
	int cycle_count = 0;

	codon_translation_histogram dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_beat(action, nucleotide, acid_select);
			if (pop && !empty)
				sb.check_beat(acid_valid, acid_code, stop_seen, in_protein,
					selected_count, total_count);
		end
	end

	// Result side: pops with random stall bursts until the closing stretch.
	initial begin
		int stall;
		stall = 0;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (calm) begin
				pop = 1'b1;
			end else if (stall > 0) begin
				stall--;
				pop = 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 12) - 1;
				pop = 1'b0;
			end else begin
				pop = 1'b1;
			end
		end
	end

	function automatic logic [4:0] random_sel();
		if ($urandom_range(0, 3) == 0)
			return 5'($urandom_range(0, 31));
		return 5'($urandom_range(0, NUM_ACIDS - 1));
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_beat(input logic [1:0] act, input logic [7:0] nuc, input logic [4:0] sel);
		int gap;
		if (!calm && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 12);
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push = 1'b1;
		action = act;
		nucleotide = nuc;
		acid_select = sel;
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
		items_sent++;
		calm = (items_sent >= CALM_AFTER);
	endtask

	task automatic feed_base(input logic [1:0] b);
		if ($urandom_range(0, 11) == 0)
			send_beat(ACT_FEED, 8'($urandom_range(0, 255)), random_sel());
		if ($urandom_range(0, 9) == 0)
			send_beat($urandom_range(0, 1) ? ACT_READ : ACT_SPARE,
				8'($urandom_range(0, 255)), random_sel());
		send_beat(ACT_FEED, base_char(b), random_sel());
	endtask

	task automatic feed_codon(input logic [1:0] b1, input logic [1:0] b2, input logic [1:0] b3);
		feed_base(b1);
		feed_base(b2);
		feed_base(b3);
	endtask

	// Junk, a start codon, a few codons, and usually a stop codon to close the gene.
	task automatic send_gene();
		int codons;
		int ending;
		logic [1:0] b1;
		logic [1:0] b2;
		logic [1:0] b3;
		repeat ($urandom_range(0, 5))
			feed_base(2'($urandom_range(0, 3)));
		feed_codon(BASE_A, BASE_T, BASE_G);
		codons = $urandom_range(0, 10);
		repeat (codons) begin
			// Mostly keep stops out of the body so proteins run long.
			do begin
				b1 = 2'($urandom_range(0, 3));
				b2 = 2'($urandom_range(0, 3));
				b3 = 2'($urandom_range(0, 3));
			end while (translate_codon(b1, b2, b3) == CODON_STOP && $urandom_range(0, 7) != 0);
			feed_codon(b1, b2, b3);
		end
		ending = $urandom_range(0, 19);
		if (ending == 0) begin
			send_beat(ACT_CLEAR, 8'($urandom_range(0, 255)), random_sel());
		end else if (ending == 1) begin
			feed_base(2'($urandom_range(0, 3)));
		end else if (ending > 2) begin
			case ($urandom_range(0, 2))
				0: feed_codon(BASE_T, BASE_A, BASE_A);
				1: feed_codon(BASE_T, BASE_A, BASE_G);
				default: feed_codon(BASE_T, BASE_G, BASE_A);
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		action = ACT_FEED;
		nucleotide = 8'h00;
		acid_select = 5'd0;
		items_sent = 0;
		calm = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_beat(ACT_READ, 8'h00, 5'd0);
		send_beat(ACT_SPARE, 8'hFF, 5'd31);
		send_beat(ACT_FEED, CHAR_A, 5'd10);
		send_beat(ACT_FEED, CHAR_T, 5'd10);
		send_beat(ACT_FEED, CHAR_G, 5'd10);
		send_beat(ACT_FEED, 8'h00, 5'd20);
		send_beat(ACT_FEED, 8'hFF, 5'd4);
		// A lowercase base in the middle of a codon must be skipped.
		send_beat(ACT_FEED, CHAR_T, 5'd4);
		send_beat(ACT_FEED, 8'h74, 5'd4);
		send_beat(ACT_FEED, CHAR_T, 5'd4);
		send_beat(ACT_FEED, CHAR_T, 5'd4);
		send_beat(ACT_FEED, CHAR_T, 5'd18);
		send_beat(ACT_FEED, CHAR_G, 5'd18);
		send_beat(ACT_FEED, CHAR_G, 5'd18);
		send_beat(ACT_FEED, CHAR_T, 5'd19);
		send_beat(ACT_FEED, CHAR_G, 5'd19);
		send_beat(ACT_FEED, CHAR_A, 5'd19);
		send_beat(ACT_FEED, CHAR_A, 5'd10);
		send_beat(ACT_FEED, CHAR_A, 5'd10);
		send_beat(ACT_FEED, CHAR_T, 5'd10);
		send_beat(ACT_FEED, CHAR_G, 5'd10);
		send_beat(ACT_FEED, CHAR_G, 5'd0);
		send_beat(ACT_FEED, CHAR_C, 5'd0);
		send_beat(ACT_FEED, CHAR_C, 5'd0);
		send_beat(ACT_CLEAR, CHAR_A, 5'd0);
		send_beat(ACT_READ, CHAR_G, 5'd10);

		while (items_sent < ITEM_TARGET)
			send_gene();
		push = 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

>>> filelist.f
design/cth_pkg.sv
design/cth_front.sv
design/cth_fifo.sv
design/cth_back.sv
design/codon_translation_histogram.sv
verif/tb_top.sv
